>>> rtl/segment_intersection_test_core_assert.svh
// Assertion macros for the segment intersection test core.
`ifndef SEGMENT_INTERSECTION_TEST_CORE_ASSERT_SVH
`define SEGMENT_INTERSECTION_TEST_CORE_ASSERT_SVH

// Consequent must hold whenever the antecedent does (clock and reset by name).
`define SIT_ASSERT_IMPLIES(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Expression must never be true outside reset.
`define SIT_ASSERT_NEVER(lbl, expr, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) !(expr)) \
      else $error(msg);

`endif

>>> rtl/sit_pkg.sv
// Shared types, widths and helper functions for the segment intersection test core.
`default_nettype none

package sit_pkg;

   localparam int COORD_WIDTH = 16;
   localparam int DIFF_WIDTH  = COORD_WIDTH + 1;
   localparam int PROD_WIDTH  = 2 * DIFF_WIDTH;

   typedef logic signed [COORD_WIDTH-1:0] coord_type;
   typedef logic signed [DIFF_WIDTH-1:0]  diff_type;
   typedef logic signed [PROD_WIDTH-1:0]  prod_type;

   typedef struct packed {
      coord_type x;
      coord_type y;
   } point_type;

   typedef struct packed {
      coord_type p1_x;
      coord_type p1_y;
      coord_type p2_x;
      coord_type p2_y;
      coord_type q1_x;
      coord_type q1_y;
      coord_type q2_x;
      coord_type q2_y;
   } req_word_type;

   typedef struct packed {
      logic hit;
      logic proper_crossing;
   } rsp_word_type;

   // orientation sign: both low means collinear
   typedef struct packed {
      logic pos;
      logic neg;
   } sign_type;

   function automatic logic in_range(coord_type a, coord_type b, coord_type c);
      return ((a <= c) && (c <= b)) || ((a >= c) && (c >= b));
   endfunction

   // c lies between the ends of a-b: on x, or on y for a vertical segment
   function automatic logic seg_range(point_type a, point_type b, point_type c);
      logic r;
      if (a.x != b.x) begin
         r = in_range(a.x, b.x, c.x);
      end else begin
         r = in_range(a.y, b.y, c.y);
      end
      return r;
   endfunction

endpackage

`default_nettype wire

>>> rtl/segment_intersection_test_core.sv
// Top level of the segment intersection test core: four orientation pipes and the verdict.
//
//  channel | ports                        | handshake
//  --------+------------------------------+-----------------------------------
//  request | start, busy, req_word        | word taken when start & !busy
//  result  | rsp_valid, rsp_word          | one-cycle strobe, cannot be held
//
// A word runs through the orientation pipe (difference, multiply, compare)
// and then the verdict register; one word may be taken every cycle.
// busy is never raised: nothing in the pipe waits on the receiver.
// Synchronous active-high reset clears the valid bits only; data registers
// are not reset.
`default_nettype none

module segment_intersection_test_core
   import sit_pkg::*;
(
   input  wire          clock,
   input  wire          reset,
   input  wire          start,
   output logic         busy,
   input  req_word_type req_word,
   output logic         rsp_valid,
   output rsp_word_type rsp_word
);

   point_type p1, p2, q1, q2;
   sign_type  o1, o2, o3, o4;

   // valid bits travelling with the orientation pipe
   logic v1_ff, v2_ff, v3_ff;
   logic v1_in, v2_in, v3_in;

   // end-range flags for on-segment tests: q1 on P, q2 on P, p1 on Q, p2 on Q
   logic [3:0] rng1_ff, rng2_ff, rng3_ff;
   logic [3:0] rng1_in;

   logic         rsp_valid_ff, rsp_valid_in;
   rsp_word_type rsp_word_ff, rsp_word_in;
   logic         proper;
   logic [3:0]   on_seg;

   assign busy = 1'b0;

   assign p1 = '{x: req_word.p1_x, y: req_word.p1_y};
   assign p2 = '{x: req_word.p2_x, y: req_word.p2_y};
   assign q1 = '{x: req_word.q1_x, y: req_word.q1_y};
   assign q2 = '{x: req_word.q2_x, y: req_word.q2_y};

   sit_orient u_o1 (.clock(clock), .a(p1), .b(p2), .c(q1), .sgn(o1));
   sit_orient u_o2 (.clock(clock), .a(p1), .b(p2), .c(q2), .sgn(o2));
   sit_orient u_o3 (.clock(clock), .a(q1), .b(q2), .c(p1), .sgn(o3));
   sit_orient u_o4 (.clock(clock), .a(q1), .b(q2), .c(p2), .sgn(o4));

   // range tests are cheap: do them up front, then delay to meet the signs
   always_comb begin
      rng1_in[0] = seg_range(p1, p2, q1);
      rng1_in[1] = seg_range(p1, p2, q2);
      rng1_in[2] = seg_range(q1, q2, p1);
      rng1_in[3] = seg_range(q1, q2, p2);
   end

   assign v1_in = start & ~busy;
   assign v2_in = v1_ff;
   assign v3_in = v2_ff;

   // verdict: strict crossing needs every sign non-zero and opposite pairs
   always_comb begin
      proper = (o1.pos | o1.neg) & (o2.pos | o2.neg) &
               (o3.pos | o3.neg) & (o4.pos | o4.neg) &
               (o1.pos != o2.pos) & (o3.pos != o4.pos);
      on_seg[0] = ~(o1.pos | o1.neg) & rng3_ff[0];
      on_seg[1] = ~(o2.pos | o2.neg) & rng3_ff[1];
      on_seg[2] = ~(o3.pos | o3.neg) & rng3_ff[2];
      on_seg[3] = ~(o4.pos | o4.neg) & rng3_ff[3];
      rsp_word_in.proper_crossing = proper;
      rsp_word_in.hit             = proper | (|on_seg);
      rsp_valid_in                = v3_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         v1_ff        <= v1_in;
         v2_ff        <= v2_in;
         v3_ff        <= v3_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rng1_ff     <= rng1_in;
      rng2_ff     <= rng1_ff;
      rng3_ff     <= rng2_ff;
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

`include "segment_intersection_test_core_assert.svh"

   // every strobe traces back to a word that was taken
   `SIT_ASSERT_IMPLIES(a_rsp_from_req, rsp_valid, $past(start, 4), "result without request")

   // a word taken with no reset behind it comes out as a strobe
   `SIT_ASSERT_IMPLIES(a_req_gives_rsp, $past(start, 4) && !$past(reset, 4) && !$past(reset, 3) && !$past(reset, 2) && !$past(reset, 1), rsp_valid, "request lost")

   // strict crossing always counts as a hit
   `SIT_ASSERT_NEVER(a_proper_hit, rsp_valid && rsp_word.proper_crossing && !rsp_word.hit, "crossing without hit")

endmodule

`default_nettype wire

>>> rtl/sit_orient.sv
// Three-stage orientation unit: differences, products, compare.
`default_nettype none

module sit_orient
   import sit_pkg::*;
(
   input  wire       clock,
   input  point_type a,
   input  point_type b,
   input  point_type c,
   output sign_type  sgn
);

   diff_type bx_ff, cy_ff, cx_ff, by_ff;
   diff_type bx_in, cy_in, cx_in, by_in;
   prod_type t1_ff, t2_ff, t1_in, t2_in;
   sign_type sgn_ff, sgn_in;

   // stage 1: edge vectors, one bit wider so they never wrap
   always_comb begin
      bx_in = diff_type'(b.x) - diff_type'(a.x);
      cy_in = diff_type'(c.y) - diff_type'(a.y);
      cx_in = diff_type'(c.x) - diff_type'(a.x);
      by_in = diff_type'(b.y) - diff_type'(a.y);
   end

   // stage 2: the two cross terms at full width
   always_comb begin
      t1_in = prod_type'(bx_ff) * prod_type'(cy_ff);
      t2_in = prod_type'(cx_ff) * prod_type'(by_ff);
   end

   // stage 3: compare rather than subtract
   always_comb begin
      sgn_in.pos = t1_ff > t2_ff;
      sgn_in.neg = t1_ff < t2_ff;
   end

   always_ff @(posedge clock) begin
      bx_ff  <= bx_in;
      cy_ff  <= cy_in;
      cx_ff  <= cx_in;
      by_ff  <= by_in;
      t1_ff  <= t1_in;
      t2_ff  <= t2_in;
      sgn_ff <= sgn_in;
   end

   assign sgn = sgn_ff;

endmodule

`default_nettype wire
